### hdl/asl_pkg.sv
// ----------------------------------------------------------------------------
// Ascending list sorter package
// Shared types for the insertion chain and its control.
// ----------------------------------------------------------------------------
package asl_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Controller state, one-hot.
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic   insert;  // place value at its ordered position
    logic   shift;   // move every entry one cell towards the head
    value_t value;   // value being inserted
  } chain_ctrl_t;

endpackage

### hdl/asl_cell.sv
// ----------------------------------------------------------------------------
// Ascending list sorter cell
// One entry of the sorted chain with its compare and neighbour hand-over.
// ----------------------------------------------------------------------------
module asl_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  asl_pkg::chain_ctrl_t ctrl,
  input  logic                 prev_take,
  input  asl_pkg::value_t      prev_val,
  input  logic                 prev_valid,
  input  asl_pkg::value_t      next_val,
  input  logic                 next_valid,
  output asl_pkg::value_t      val,
  output logic                 valid,
  output logic                 take
);
  import asl_pkg::*;

  // The cell gives way when it is empty or holds a larger value.
  assign take = !valid || (val > ctrl.value);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val <= next_val;
    end else if (ctrl.insert && take) begin
      val <= prev_take ? prev_val : ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.insert && take) begin
      valid <= prev_take ? prev_valid : 1'b1;
    end
  end

endmodule

### hdl/ascending_list_sorter_unit.sv
// ----------------------------------------------------------------------------
// Ascending list sorter unit
// Sorts a list of signed 32-bit values with a systolic insertion chain.
// ----------------------------------------------------------------------------
// Sequence: an input transaction is written into the chain on the clock edge
//   that accepts it; after the tlast transaction the controller enters draining,
//   and the first result then moves into the output register once it is free.
// Throughput: one input transaction per cycle while a list is loading, then
//   one result per cycle while draining as long as the output is not stalled
//   by m_tready; the input is closed while the chain drains.
// Reset: rst is synchronous and active high; it empties the chain and clears
//   the drop flag and the output register's valid.
// ----------------------------------------------------------------------------
module ascending_list_sorter_unit #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] item_value
  input  logic        s_tlast,   // list_end
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,   // run_end
  output logic        m_tuser    // [0] items_dropped
);
  import asl_pkg::*;

  // The fill count has to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   fill_count;
  logic               overflow_seen;
  logic               in_fire;
  logic               full;
  logic               out_free;
  logic               drain_step;
  logic               drain_last;
  chain_ctrl_t        ctrl;

  value_t             cell_val   [CAPACITY];
  logic               cell_valid [CAPACITY];
  logic               cell_take  [CAPACITY];

  // Items are taken only while a list is loading. The output register keeps
  // its own handshake, so a last result still waiting does not hold up the
  // next list.
  assign s_tready   = (state == ST_LOAD);
  assign in_fire    = s_tvalid && s_tready;
  assign full       = (fill_count == CNT_W'(CAPACITY));

  // The chain drains one entry into the output register whenever that
  // register is empty or its content is being taken in this cycle.
  assign out_free   = !m_tvalid || m_tready;
  assign drain_step = (state == ST_DRAIN) && out_free;
  assign drain_last = drain_step && (fill_count == CNT_W'(1));

  // A value arriving at a full chain is dropped; the list still ends on it.
  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = drain_step;
  assign ctrl.value  = value_t'(s_tdata);

  // The chain: each cell compares against the broadcast value and either
  // keeps its entry, takes the new value, or takes its left neighbour's entry
  // so that the tail moves up by one. Draining moves everything to the head.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   p_take;
    value_t p_val;
    logic   p_valid;
    value_t n_val;
    logic   n_valid;

    if (i == 0) begin : g_head
      assign p_take  = 1'b0;
      assign p_val   = '0;
      assign p_valid = 1'b0;
    end else begin : g_body
      assign p_take  = cell_take[i-1];
      assign p_val   = cell_val[i-1];
      assign p_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_val   = '0;
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_val   = cell_val[i+1];
      assign n_valid = cell_valid[i+1];
    end

    asl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_take  (p_take),
      .prev_val   (p_val),
      .prev_valid (p_valid),
      .next_val   (n_val),
      .next_valid (n_valid),
      .val        (cell_val[i]),
      .valid      (cell_valid[i]),
      .take       (cell_take[i])
    );
  end

  // Loading switches to draining on the list's final transaction; draining
  // returns to loading once the last entry has left the chain.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_fire && s_tlast) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_last) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.insert) begin
        fill_count <= fill_count + CNT_W'(1);
      end else if (drain_step) begin
        fill_count <= fill_count - CNT_W'(1);
      end
      if (in_fire && full) begin
        overflow_seen <= 1'b1;
      end else if (drain_last) begin
        overflow_seen <= 1'b0;
      end
    end
  end

  // Output register, fed from the head of the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (drain_step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_step) begin
      m_tdata <= cell_val[0];
      m_tlast <= drain_last;
      m_tuser <= overflow_seen;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // The count never exceeds the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // The head cell holds an entry exactly when the count is non-zero.
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    cell_valid[0] == (fill_count != '0))
    else $error("head cell validity disagrees with fill count");

  // Draining always has something to emit.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (fill_count != '0))
    else $error("draining an empty chain");

  // After the final entry leaves, the chain is empty and loading resumes.
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    drain_last |=> (state == ST_LOAD) && (fill_count == '0) && !overflow_seen
      && m_tvalid && m_tlast)
    else $error("list end did not leave an empty chain");

endmodule
